>>> src/ptr_pkg.sv
// Shared types and constants for the paper tape reader framer.
package ptr_pkg;

    // Item kinds
    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_BYTE    = 3'd1;
    localparam logic [2:0] OP_TICK    = 3'd2;
    localparam logic [2:0] OP_EOT     = 3'd3;
    localparam logic [2:0] OP_MOUNTED = 3'd4;

    localparam logic [1:0] DEV_ALPHA = 2'd1;

    localparam logic [7:0]  FRAME_MARK  = 8'o200;
    localparam logic [7:0]  SIX_BITS    = 8'o077;
    localparam logic [7:0]  EIGHT_BITS  = 8'o377;
    localparam logic [17:0] WAIT_BITS   = 18'o014000;
    localparam logic [15:0] DELAY_RESET = 16'd2500;
    localparam logic [1:0]  LAST_CHAR   = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  device;
        logic [17:0] mb_word;
        logic [7:0]  tape_byte;
        logic        read_in_mode;
    } t_in_item;

    typedef struct packed {
        logic        byte_taken;
        logic        word_done;
        logic        io_load;
        logic [17:0] io_word;
        logic        break_request;
        logic        read_in_done;
        logic        io_status;
        logic        buffer_status;
        logic [17:0] buffer_word;
    } t_out_item;

endpackage

>>> src/ptr_in_if.sv
// Input channel: one reader event per item.
interface ptr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [1:0]  device;
    logic [17:0] mb_word;
    logic [7:0]  tape_byte;
    logic        read_in_mode;

    modport source (output valid, op, device, mb_word, tape_byte, read_in_mode, input ready);
    modport sink   (input valid, op, device, mb_word, tape_byte, read_in_mode, output ready);
endinterface

>>> src/ptr_out_if.sv
// Output channel: one reader result per item.
interface ptr_out_if;
    logic        valid;
    logic        ready;
    logic        byte_taken;
    logic        word_done;
    logic        io_load;
    logic [17:0] io_word;
    logic        break_request;
    logic        read_in_done;
    logic        io_status;
    logic        buffer_status;
    logic [17:0] buffer_word;

    modport source (output valid, byte_taken, word_done, io_load, io_word, break_request,
                     read_in_done, io_status, buffer_status, buffer_word, input ready);
    modport sink   (input valid, byte_taken, word_done, io_load, io_word, break_request,
                    read_in_done, io_status, buffer_status, buffer_word, output ready);
endinterface

>>> src/ptr_core.sv
// Reader state and the per-item decision logic.
module ptr_core
    import ptr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  t_in_item    i_item,
    input  logic [15:0] i_delay_ticks,
    output t_out_item   o_result
);

    logic        r_armed, n_armed;
    logic [1:0]  r_char_count, n_char_count;
    logic        r_binary_mode, n_binary_mode;
    logic        r_wait_mode, n_wait_mode;
    logic [17:0] r_buffer, n_buffer;
    logic [15:0] r_delay_count, n_delay_count;
    logic        r_tape_present, n_tape_present;
    logic        r_io_flag, n_io_flag;
    logic        r_buffer_flag, n_buffer_flag;

    logic        byte_ok;
    logic [17:0] buf_or;
    logic [7:0]  char_mask;

    assign char_mask = r_binary_mode ? SIX_BITS : EIGHT_BITS;
    assign buf_or    = r_buffer | {10'd0, i_item.tape_byte & char_mask};
    assign byte_ok   = r_armed && (r_delay_count == 16'd0) && r_tape_present;

    always_comb begin
        n_armed        = r_armed;
        n_char_count   = r_char_count;
        n_binary_mode  = r_binary_mode;
        n_wait_mode    = r_wait_mode;
        n_buffer       = r_buffer;
        n_delay_count  = r_delay_count;
        n_tape_present = r_tape_present;
        n_io_flag      = r_io_flag;
        n_buffer_flag  = r_buffer_flag;
        o_result       = '0;

        case (i_item.op)
            OP_READ: begin
                n_wait_mode = (i_item.mb_word & WAIT_BITS) != 18'd0;
                if (i_item.device == DEV_ALPHA) begin
                    n_binary_mode = 1'b0;
                    n_char_count  = 2'd3;
                    n_armed       = !r_armed;
                end else begin
                    n_binary_mode = 1'b1;
                    n_char_count  = 2'd1;
                    n_armed       = 1'b1;
                end
                n_delay_count = i_delay_ticks;
                n_buffer      = '0;
            end
            OP_BYTE: begin
                if (byte_ok) begin
                    o_result.byte_taken = 1'b1;
                    n_delay_count       = i_delay_ticks;
                    if (r_char_count != 2'd0 &&
                        (!r_binary_mode || (i_item.tape_byte & FRAME_MARK) != 8'd0)) begin
                        n_armed  = 1'b0;
                        n_buffer = buf_or;
                        if (r_char_count != LAST_CHAR) begin
                            n_buffer = {buf_or[11:0], 6'd0};
                            n_armed  = 1'b1;
                        end else begin
                            o_result.word_done = 1'b1;
                            if (r_wait_mode) n_io_flag = 1'b1;
                            else             n_buffer_flag = 1'b1;
                            if (r_wait_mode || i_item.read_in_mode) begin
                                o_result.io_load      = 1'b1;
                                o_result.io_word      = buf_or;
                                n_buffer_flag         = 1'b0;
                                o_result.read_in_done = i_item.read_in_mode;
                            end
                            o_result.break_request = !i_item.read_in_mode;
                        end
                        n_char_count = r_char_count + 2'd1;
                    end
                end
            end
            OP_TICK: begin
                if (r_delay_count != 16'd0) n_delay_count = r_delay_count - 16'd1;
            end
            OP_EOT:     n_tape_present = 1'b0;
            OP_MOUNTED: n_tape_present = 1'b1;
            default: ;
        endcase

        o_result.io_status     = n_io_flag;
        o_result.buffer_status = n_buffer_flag;
        o_result.buffer_word   = n_buffer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed        <= 1'b0;
            r_char_count   <= 2'd0;
            r_binary_mode  <= 1'b0;
            r_wait_mode    <= 1'b0;
            r_buffer       <= '0;
            r_delay_count  <= '0;
            r_tape_present <= 1'b1;
            r_io_flag      <= 1'b0;
            r_buffer_flag  <= 1'b0;
        end else if (i_go) begin
            r_armed        <= n_armed;
            r_char_count   <= n_char_count;
            r_binary_mode  <= n_binary_mode;
            r_wait_mode    <= n_wait_mode;
            r_buffer       <= n_buffer;
            r_delay_count  <= n_delay_count;
            r_tape_present <= n_tape_present;
            r_io_flag      <= n_io_flag;
            r_buffer_flag  <= n_buffer_flag;
        end
    end

endmodule

>>> src/ptr_outq.sv
// Two-entry result buffer in front of the output channel.
module ptr_outq
    import ptr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_data,
    input  logic      i_pop_ready,
    output logic      o_valid,
    output logic      o_room,
    output t_out_item o_data
);

    logic [1:0] r_cnt, n_cnt;
    t_out_item  r_q [2];
    logic       pop;
    logic       wr_idx;

    assign o_valid = r_cnt != 2'd0;
    assign pop     = o_valid && i_pop_ready;
    assign o_room  = (r_cnt != 2'd2) || pop;
    assign o_data  = r_q[0];
    assign n_cnt   = r_cnt + {1'b0, i_push} - {1'b0, pop};
    // push lands behind whatever is still held after this cycle's pop
    assign wr_idx  = (r_cnt == 2'd2) || (r_cnt == 2'd1 && !pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= 2'd0;
        else          r_cnt <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_cnt == 2'd2) r_q[0] <= r_q[1];
        if (i_push) r_q[wr_idx] <= i_data;
    end

endmodule

>>> src/paper_tape_reader_framer.sv
// Top level of the paper tape reader framer.
//
//  channel  dir  handshake          carries
//  i_in     in   valid/ready        op, device, mb_word, tape_byte, read_in_mode
//  o_out    out  valid/ready        flags, io_word, status flags, buffer_word
//  cfg      in   i_cfg_we (no wait) delay_ticks, 16 bits
//
//  An item is registered on acceptance, decided combinationally from the input register
//  and written to a two-entry result buffer when it has room. One item per cycle is
//  sustained unless the output stalls, with one decision stage between input and buffer.
//  While the output stalls, up to three items are held (input register plus buffer)
//  before i_in.ready drops.
//  Reset (synchronous, active low) empties the pipeline, loads delay_ticks with 2500,
//  clears the reader state and marks tape as present.
module paper_tape_reader_framer
    import ptr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptr_in_if.sink      i_in,
    ptr_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic [15:0] r_delay_ticks;
    logic        q_room;
    logic        advance;
    t_out_item   result;
    t_out_item   q_data;

    // Config register; the user must write it only while the block is idle; not enforced here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_delay_ticks <= DELAY_RESET;
        else if (i_cfg_we) r_delay_ticks <= i_cfg_wdata;
    end

    // Input register stage: it drains into the result buffer whenever there is room.
    assign advance    = r_in_valid && q_room;
    assign i_in.ready = !r_in_valid || q_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)        r_in_valid <= 1'b0;
        else if (i_in.ready) r_in_valid <= i_in.valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.op           <= i_in.op;
            r_in.device       <= i_in.device;
            r_in.mb_word      <= i_in.mb_word;
            r_in.tape_byte    <= i_in.tape_byte;
            r_in.read_in_mode <= i_in.read_in_mode;
        end
    end

    // Decision logic; reader state moves only when the item is passed on.
    ptr_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (advance),
        .i_item        (r_in),
        .i_delay_ticks (r_delay_ticks),
        .o_result      (result)
    );

    ptr_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (advance),
        .i_data      (result),
        .i_pop_ready (o_out.ready),
        .o_valid     (o_out.valid),
        .o_room      (q_room),
        .o_data      (q_data)
    );

    assign o_out.byte_taken    = q_data.byte_taken;
    assign o_out.word_done     = q_data.word_done;
    assign o_out.io_load       = q_data.io_load;
    assign o_out.io_word       = q_data.io_word;
    assign o_out.break_request = q_data.break_request;
    assign o_out.read_in_done  = q_data.read_in_done;
    assign o_out.io_status     = q_data.io_status;
    assign o_out.buffer_status = q_data.buffer_status;
    assign o_out.buffer_word   = q_data.buffer_word;

endmodule

>>> src/ptr_checker.sv
// Port-level checks for the paper tape reader framer, bound to the top level.
module ptr_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_byte_taken,
    input logic        i_word_done,
    input logic        i_io_load,
    input logic [17:0] i_io_word,
    input logic        i_break_request,
    input logic        i_read_in_done
);

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a held result keeps its word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_io_word))
        else $error("stalled result changed");

    a_done_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_word_done |-> i_byte_taken)
        else $error("completion without a consumed byte");

    a_word_only_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_io_load |-> i_io_word == 18'd0)
        else $error("io_word set without io_load");

    // break and read-in return are exclusive outcomes of a completion
    a_break_or_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_break_request || i_read_in_done) |->
            i_word_done && !(i_break_request && i_read_in_done))
        else $error("bad completion outcome");

endmodule

bind paper_tape_reader_framer ptr_port_checks u_ptr_port_checks (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_byte_taken    (o_out.byte_taken),
    .i_word_done     (o_out.word_done),
    .i_io_load       (o_out.io_load),
    .i_io_word       (o_out.io_word),
    .i_break_request (o_out.break_request),
    .i_read_in_done  (o_out.read_in_done)
);
